@@ src/windowed_slope_runaway_monitor_core_macros.svh @@
// Assertion macros shared by the monitor core.
`ifndef WINDOWED_SLOPE_RUNAWAY_MONITOR_CORE_MACROS_SVH
`define WINDOWED_SLOPE_RUNAWAY_MONITOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define WSRM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wsrm assertion failed");

// Next-cycle implication, disabled while reset is low.
`define WSRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wsrm assertion failed");

`endif

@@ src/wsrm_pkg.sv @@
package wsrm_pkg;

    // Default window depth.
    localparam int WINDOW_DEPTH_DEF = 8;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PUSH_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPAN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_NUM    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FALLING     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN     = 3'd6;

    // Register reset values.
    localparam logic [15:0] RST_PUSH_PERIOD = 16'd1000;
    localparam logic [15:0] RST_MIN_SPAN    = 16'd2000;
    localparam logic [8:0]  RST_ALPHA       = 9'd51;
    localparam logic [15:0] RST_RATE_NUM    = 16'd6000;
    localparam logic [23:0] RST_THRESHOLD   = 24'd2560;
    localparam logic        RST_FALLING     = 1'b0;
    localparam logic [15:0] RST_SUSTAIN     = 16'd2000;

    // Arithmetic widths.
    localparam int VAL_W  = 24;
    localparam int TIME_W = 32;
    localparam int PROD_W = 35;
    localparam int NUM_W  = 42;
    localparam int MAG_W  = 41;

    localparam logic [8:0] ALPHA_ONE = 9'd256;
    localparam logic signed [VAL_W-1:0] SLOPE_MAX = 24'sh7FFFFF;
    localparam logic signed [VAL_W-1:0] SLOPE_MIN = 24'sh800000;

endpackage

@@ src/windowed_slope_runaway_monitor_core.sv @@
// Each accepted input beat goes through the filter, ring push, ring scan through the memory
// port, multiply and divide states to its result beat; the division steps are skipped when no
// valid slope is possible. One sample at a time: o_stall is high until the result beat is
// issued, after the one-bit-per-cycle restoring divider (41 steps), the ring scan and any
// wait of the result beat on the output stall.
// Reset (synchronous, active low) clears the filter, ring fill count, alarm tracking and lock,
// and loads the register defaults; ring memory contents are not cleared.
`include "windowed_slope_runaway_monitor_core_macros.svh"
module windowed_slope_runaway_monitor_core
    import wsrm_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [15:0]          i_sample,
    input  logic [TIME_W-1:0]           i_now_ms,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [VAL_W-1:0]     o_slope,
    output logic                        o_slope_valid,
    output logic                        o_over_limit,
    output logic                        o_locked,
    output logic signed [VAL_W-1:0]     o_filtered_value
);

    localparam int AW     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int DCNT_W = $clog2(MAG_W + 2);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILT = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_PUSH = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    typedef struct packed {
        logic [TIME_W-1:0] t;
        logic [VAL_W-1:0]  v;
    } t_point;

    // Configuration registers.
    logic [15:0]             r_push_period, r_min_span, r_rate_num, r_sustain;
    logic [8:0]              r_alpha;
    logic signed [VAL_W-1:0] r_threshold;
    logic                    r_falling;

    // Processing state.
    logic [2:0]              r_state;
    logic signed [VAL_W-1:0] r_x;
    logic [TIME_W-1:0]       r_now;
    logic signed [VAL_W-1:0] r_acc;
    logic                    r_started;
    logic [TIME_W-1:0]       r_last;
    logic [AW-1:0]           r_wpos;
    logic [FILL_W-1:0]       r_fill;
    logic [FILL_W-1:0]       r_idx;
    logic                    r_rdv;
    t_point                  r_rd;
    logic [TIME_W-1:0]       r_span;
    logic signed [VAL_W-1:0] r_old;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [NUM_W-1:0] r_num;
    logic                    r_neg;
    logic [MAG_W-1:0]        r_quo;
    logic [TIME_W-1:0]       r_rem;
    logic [DCNT_W-1:0]       r_dcnt;
    logic                    r_svalid;
    logic [TIME_W-1:0]       r_over_start;
    logic                    r_over_active;
    logic                    r_lock;
    logic                    r_ovalid;

    t_point mem [WINDOW_DEPTH];

    // Combinational helpers.
    logic [8:0]              alpha_c;
    logic signed [VAL_W:0]   fdiff;
    logic signed [PROD_W-1:0] fround;
    logic [TIME_W-1:0]       limit;
    logic [TIME_W-1:0]       age;
    logic                    issue;
    logic                    push;
    logic signed [VAL_W:0]   sdiff;
    logic [TIME_W:0]         trial;
    logic                    tbit;
    logic signed [VAL_W-1:0] slope_c;
    logic                    over_c;
    logic                    out_free;

    assign alpha_c  = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
    assign fdiff    = {r_x[VAL_W-1], r_x} - {r_acc[VAL_W-1], r_acc};
    assign fround   = (r_prod + PROD_W'(128)) >>> 8;
    assign limit    = TIME_W'(r_push_period) * TIME_W'(WINDOW_DEPTH);
    assign age      = r_now - r_rd.t;
    assign issue    = (r_idx < r_fill);
    assign push     = ((r_now - r_last) >= TIME_W'(r_push_period));
    assign sdiff    = {r_acc[VAL_W-1], r_acc} - {r_old[VAL_W-1], r_old};
    assign trial    = {r_rem, r_quo[MAG_W-1]};
    assign tbit     = (trial >= {1'b0, r_span});
    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);

    // Saturated signed slope from the divider result.
    always_comb begin
        slope_c = '0;
        if (r_svalid) begin
            if (r_neg) begin
                if (r_quo > MAG_W'(8388608)) slope_c = SLOPE_MIN;
                else slope_c = -$signed(r_quo[VAL_W-1:0]);
            end else begin
                if (r_quo > MAG_W'(8388607)) slope_c = SLOPE_MAX;
                else slope_c = $signed(r_quo[VAL_W-1:0]);
            end
        end
        over_c = r_svalid && (r_falling ? (slope_c < r_threshold) : (slope_c > r_threshold));
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_push_period <= RST_PUSH_PERIOD;
            r_min_span    <= RST_MIN_SPAN;
            r_alpha       <= RST_ALPHA;
            r_rate_num    <= RST_RATE_NUM;
            r_threshold   <= RST_THRESHOLD;
            r_falling     <= RST_FALLING;
            r_sustain     <= RST_SUSTAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PUSH_PERIOD: r_push_period <= i_cfg_data[15:0];
                REG_MIN_SPAN:    r_min_span    <= i_cfg_data[15:0];
                REG_ALPHA:       r_alpha       <= i_cfg_data[8:0];
                REG_RATE_NUM:    r_rate_num    <= i_cfg_data[15:0];
                REG_THRESHOLD:   r_threshold   <= $signed(i_cfg_data);
                REG_FALLING:     r_falling     <= i_cfg_data[0];
                REG_SUSTAIN:     r_sustain     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Ring memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH && push) begin
            mem[r_wpos] <= '{t: r_now, v: r_acc};
        end
        r_rd <= mem[r_idx[AW-1:0]];
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_started     <= 1'b0;
            r_acc         <= '0;
            r_last        <= '0;
            r_wpos        <= '0;
            r_fill        <= '0;
            r_over_start  <= '0;
            r_over_active <= 1'b0;
            r_lock        <= 1'b0;
            r_ovalid      <= 1'b0;
            r_rdv         <= 1'b0;
        end else begin
            // The result stage reloads the beat itself when it issues a new one.
            if (r_ovalid && !i_stall && r_state != S_FIN) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_x     <= VAL_W'({i_sample, 8'd0});
                        r_now   <= i_now_ms;
                        r_state <= S_FILT;
                    end
                end
                // Filter product, or first-sample load.
                S_FILT: begin
                    if (!r_started) begin
                        r_acc     <= r_x;
                        r_started <= 1'b1;
                        r_last    <= r_now;
                        r_state   <= S_PUSH;
                    end else begin
                        r_prod  <= fdiff * $signed({1'b0, alpha_c});
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_acc   <= r_acc + fround[VAL_W-1:0];
                    r_state <= S_PUSH;
                end
                // Store the point when the push period has passed.
                S_PUSH: begin
                    if (push) begin
                        r_wpos <= (r_wpos == AW'(WINDOW_DEPTH - 1)) ? '0 : r_wpos + 1'b1;
                        if (r_fill < FILL_W'(WINDOW_DEPTH)) r_fill <= r_fill + 1'b1;
                        r_last <= r_now;
                    end
                    r_idx   <= '0;
                    r_rdv   <= 1'b0;
                    r_span  <= '0;
                    r_old   <= r_acc;
                    r_state <= S_SCAN;
                end
                // Walk the filled entries for the oldest point inside the window.
                S_SCAN: begin
                    if (issue) r_idx <= r_idx + 1'b1;
                    r_rdv <= issue;
                    if (r_rdv && age <= limit && age > r_span) begin
                        r_span <= age;
                        r_old  <= $signed(r_rd.v);
                    end
                    if (!issue && !r_rdv) r_state <= S_MUL;
                end
                S_MUL: begin
                    r_svalid <= (r_span != '0) && (r_span >= TIME_W'(r_min_span));
                    r_num    <= sdiff * $signed({1'b0, r_rate_num});
                    r_rem    <= '0;
                    r_dcnt   <= DCNT_W'(MAG_W + 1);
                    r_state  <= S_DIV;
                end
                // Restoring division, one quotient bit per cycle.
                S_DIV: begin
                    if (r_dcnt == DCNT_W'(MAG_W + 1)) begin
                        r_neg  <= r_num[NUM_W-1];
                        r_quo  <= r_num[NUM_W-1] ? MAG_W'(-r_num) : r_num[MAG_W-1:0];
                        r_dcnt <= r_dcnt - 1'b1;
                        if (!r_svalid) r_state <= S_FIN;
                    end else begin
                        r_rem  <= tbit ? TIME_W'(trial - {1'b0, r_span}) : trial[TIME_W-1:0];
                        r_quo  <= {r_quo[MAG_W-2:0], tbit};
                        r_dcnt <= r_dcnt - 1'b1;
                        if (r_dcnt == DCNT_W'(1)) r_state <= S_FIN;
                    end
                end
                // Alarm tracking and result beat.
                S_FIN: begin
                    if (out_free) begin
                        if (over_c) begin
                            if (!r_over_active) begin
                                r_over_active <= 1'b1;
                                r_over_start  <= r_now;
                            end else if ((r_now - r_over_start) >= TIME_W'(r_sustain)) begin
                                r_lock <= 1'b1;
                            end
                        end else begin
                            r_over_active <= 1'b0;
                        end
                        o_slope          <= slope_c;
                        o_slope_valid    <= r_svalid;
                        o_over_limit     <= over_c;
                        o_locked         <= r_lock || (over_c && r_over_active &&
                                            ((r_now - r_over_start) >= TIME_W'(r_sustain)));
                        o_filtered_value <= r_acc;
                        r_ovalid         <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;

    `WSRM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, r_state != S_IDLE)
    `WSRM_ASSERT_NEXT(a_lock_sticky, i_clk, i_rst_n, r_lock, r_lock)
    `WSRM_ASSERT_SAME(a_over_needs_valid, i_clk, i_rst_n, o_valid && o_over_limit, o_slope_valid)
    `WSRM_ASSERT_SAME(a_fill_bound, i_clk, i_rst_n, r_state == S_SCAN, r_idx <= r_fill)

endmodule

@@ tb/testbench.sv @@
module testbench;
    import wsrm_pkg::*;

    // One output beat of the monitor.
    typedef struct packed {
        logic [23:0] slope;
        logic        slope_ok;
        logic        over;
        logic        lock;
        logic [23:0] filt;
    } rate_result_t;

    // One row of the directed table.
    typedef struct {
        logic signed [15:0] sample;
        logic [31:0]        stamp;
        bit                 typed;
        rate_result_t       want;
    } rate_row_t;

    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 80;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_idx;
    logic [CFG_DATA_W-1:0]    i_cfg_data;
    logic                     i_valid;
    logic                     o_stall;
    logic signed [15:0]       i_sample;
    logic [TIME_W-1:0]        i_now_ms;
    logic                     o_valid;
    logic                     i_stall;
    logic signed [VAL_W-1:0]  o_slope;
    logic                     o_slope_valid;
    logic                     o_over_limit;
    logic                     o_locked;
    logic signed [VAL_W-1:0]  o_filtered_value;

    windowed_slope_runaway_monitor_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_sample        (i_sample),
        .i_now_ms        (i_now_ms),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_slope         (o_slope),
        .o_slope_valid   (o_slope_valid),
        .o_over_limit    (o_over_limit),
        .o_locked        (o_locked),
        .o_filtered_value(o_filtered_value)
    );

    // Shadow of the configuration registers.
    logic [15:0] cfg_push;
    logic [15:0] cfg_min_span;
    logic [8:0]  cfg_alpha;
    logic [15:0] cfg_rate;
    int          cfg_thresh;
    bit          cfg_falling;
    logic [15:0] cfg_sustain;

    // Shadow of the monitor state.
    int          filt_acc;
    bit          filt_started;
    logic [31:0] last_push_stamp;
    logic [31:0] win_stamp [8];
    int          win_value [8];
    int          win_wr;
    int          win_fill;
    logic [31:0] over_since;
    bit          over_tracking;
    bit          lock_seen;

    rate_result_t pending_rates [$];

    int  errors;
    int  beats_in;
    int  beats_out;
    int  locks_out;
    int  overs_out;
    bit  no_idle;
    bit  hold_req;
    int  hold_left;
    int  quiet_cycles;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Predict one result beat and advance the shadow state.
    function automatic rate_result_t predict_rate(input logic signed [15:0] s,
                                                  input logic [31:0] stamp);
        rate_result_t r;
        longint x;
        longint d;
        longint num;
        longint slp;
        int unsigned al;
        int unsigned lim;
        int unsigned span;
        int unsigned age;
        int oldv;
        bit ok;
        bit ovr;
        x = longint'(s) * 256;
        al = (cfg_alpha > 9'd256) ? 256 : cfg_alpha;
        if (!filt_started) begin
            filt_acc = int'(x);
            filt_started = 1'b1;
            last_push_stamp = stamp;
        end else begin
            d = longint'(al) * (x - longint'(filt_acc));
            filt_acc = int'(longint'(filt_acc) + ((d + 128) >>> 8));
        end
        // Store a window point once the push period has run out.
        if (32'(stamp - last_push_stamp) >= {16'd0, cfg_push}) begin
            win_stamp[win_wr] = stamp;
            win_value[win_wr] = filt_acc;
            win_wr = (win_wr + 1) % 8;
            if (win_fill < 8) win_fill++;
            last_push_stamp = stamp;
        end
        // Oldest point inside the window gives the span.
        lim = {16'd0, cfg_push} * 8;
        span = 0;
        oldv = filt_acc;
        for (int i = 0; i < win_fill; i++) begin
            age = 32'(stamp - win_stamp[i]);
            if (age <= lim && age > span) begin
                span = age;
                oldv = win_value[i];
            end
        end
        ok = (span > 0) && (span >= cfg_min_span);
        slp = 0;
        if (ok) begin
            num = (longint'(filt_acc) - longint'(oldv)) * longint'(cfg_rate);
            slp = num / longint'(span);
            if (slp > 8388607) slp = 8388607;
            if (slp < -8388608) slp = -8388608;
        end
        ovr = ok && (cfg_falling ? (slp < cfg_thresh) : (slp > cfg_thresh));
        // Sustain tracking and sticky lock.
        if (ovr) begin
            if (!over_tracking) begin
                over_tracking = 1'b1;
                over_since = stamp;
            end else if (32'(stamp - over_since) >= {16'd0, cfg_sustain}) begin
                lock_seen = 1'b1;
            end
        end else begin
            over_tracking = 1'b0;
        end
        r.slope = slp[23:0];
        r.slope_ok = ok;
        r.over = ovr;
        r.lock = lock_seen;
        r.filt = filt_acc[23:0];
        return r;
    endfunction

    // Write one register and mirror it in the shadow; the caller drops the enable.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[23:0];
        @(posedge i_clk);
        case (idx)
            REG_PUSH_PERIOD: cfg_push = value[15:0];
            REG_MIN_SPAN:    cfg_min_span = value[15:0];
            REG_ALPHA:       cfg_alpha = value[8:0];
            REG_RATE_NUM:    cfg_rate = value[15:0];
            REG_THRESHOLD:   cfg_thresh = {{8{value[23]}}, value[23:0]};
            REG_FALLING:     cfg_falling = value[0];
            REG_SUSTAIN:     cfg_sustain = value[15:0];
            default: ;
        endcase
    endtask

    // Wait until every expected beat has come back, then let the core settle.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_rates.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Offer one sample beat and hold it until accepted.
    task automatic send_sample(input logic signed [15:0] s, input logic [31:0] stamp,
                               input bit typed, input rate_result_t want);
        rate_result_t r;
        while (!no_idle && $urandom_range(0, 99) < 22) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample <= s;
        i_now_ms <= stamp;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        r = predict_rate(s, stamp);
        pending_rates.push_back(typed ? want : r);
        beats_in++;
    endtask

    task automatic report_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t mismatch %s: expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Receiver: random stalls, quiet stretch, and one long hold-off.
    initial begin
        i_stall = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !no_idle && ($urandom_range(0, 99) < 22);
            end
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        rate_result_t w;
        if (i_rst_n && o_valid && !i_stall) begin
            beats_out++;
            if (o_locked) locks_out++;
            if (o_over_limit) overs_out++;
            if (pending_rates.size() == 0) begin
                $display("%0t unexpected result beat, slope %0h", $time, o_slope);
                errors++;
            end else begin
                w = pending_rates.pop_front();
                report_field("slope", w.slope, $unsigned(o_slope));
                report_field("slope_valid", w.slope_ok, o_slope_valid);
                report_field("over_limit", w.over, o_over_limit);
                report_field("locked", w.lock, o_locked);
                report_field("filtered_value", w.filt, $unsigned(o_filtered_value));
            end
        end
    end

    // Watchdog on cycles with no beat moving either way.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus.
    initial begin
        rate_row_t    rows [$];
        rate_row_t    row;
        rate_result_t blank;
        int           phase_cfg [8][7];
        int           level;
        int           trend;
        int           sv;
        int           step;
        int           pick;
        logic [31:0]  stamp;

        errors = 0;
        beats_in = 0;
        beats_out = 0;
        locks_out = 0;
        overs_out = 0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_PUSH_PERIOD;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_sample = '0;
        i_now_ms = '0;
        blank = '0;

        cfg_push = RST_PUSH_PERIOD;
        cfg_min_span = RST_MIN_SPAN;
        cfg_alpha = RST_ALPHA;
        cfg_rate = RST_RATE_NUM;
        cfg_thresh = 2560;
        cfg_falling = RST_FALLING;
        cfg_sustain = RST_SUSTAIN;
        filt_acc = 0;
        filt_started = 1'b0;
        last_push_stamp = '0;
        win_wr = 0;
        win_fill = 0;
        over_since = '0;
        over_tracking = 1'b0;
        lock_seen = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. The first beat after reset loads the filter directly.
        row.typed = 1'b1;
        row.want = '{slope: 24'd0, slope_ok: 1'b0, over: 1'b0, lock: 1'b0,
                     filt: 24'h800000};
        row.sample = -16'sd32768;
        row.stamp = 32'd0;
        rows.push_back(row);
        row.typed = 1'b0;
        row.want = blank;
        // Full-scale step up, a steep rise through the window and into lock.
        for (int i = 1; i <= 12; i++) begin
            row.sample = 16'sd32767;
            row.stamp = 32'(i * 500);
            rows.push_back(row);
        end
        // Repeated timestamp, then a jump across the timestamp wrap.
        row.sample = 16'sd0;
        row.stamp = 32'd6000;
        rows.push_back(row);
        for (int i = 0; i < 6; i++) begin
            row.sample = (i % 2) ? -16'sd32768 : 16'sd32767;
            row.stamp = 32'hFFFF_F000 + 32'(i * 900);
            rows.push_back(row);
        end
        // A wide jump forward leaves every stored point outside the window.
        row.sample = 16'sd1;
        row.stamp = 32'h4000_0000;
        rows.push_back(row);
        row.sample = -16'sd1;
        row.stamp = 32'h4000_0000 + 32'd1000;
        rows.push_back(row);
        foreach (rows[i]) send_sample(rows[i].sample, rows[i].stamp, rows[i].typed,
                                      rows[i].want);

        // Register settings per phase: push, min span, alpha, rate, threshold,
        // falling, sustain. Phase zero keeps the reset values.
        phase_cfg[0] = '{1000, 2000, 51, 6000, 2560, 0, 2000};
        phase_cfg[1] = '{1, 0, 256, 65535, 0, 0, 0};
        phase_cfg[2] = '{65535, 65535, 0, 1, -8388608, 1, 65535};
        phase_cfg[3] = '{0, 0, 511, 6000, 8388607, 0, 500};
        phase_cfg[4] = '{200, 400, 128, 60000, -2560, 1, 1500};
        phase_cfg[5] = '{100, 300, 51, 6000, 2560, 0, 2000};
        phase_cfg[6] = '{1000, 0, 300, 1, -8388608, 0, 0};
        phase_cfg[7] = '{50, 100, 77, 65535, 8388607, 1, 1};

        stamp = 32'h4000_1000;
        level = 0;
        trend = 0;
        for (int ph = 0; ph < 8; ph++) begin
            if (ph > 0) begin
                drain_results();
                for (int r = 0; r < 7; r++)
                    write_reg(r[CFG_IDX_W-1:0], phase_cfg[ph][r]);
                i_cfg_we <= 1'b0;
            end
            step = (cfg_push > 1) ? cfg_push / 2 : 50;
            for (int n = 0; n < 230; n++) begin
                // Quiet stretch, long receiver hold-off and a full drain, once each.
                no_idle = (beats_in >= 600 && beats_in < 800);
                if (beats_in == 1000) hold_req = 1'b1;
                if (beats_in == 1400) begin
                    i_valid <= 1'b0;
                    while (pending_rates.size() != 0) @(posedge i_clk);
                end
                if (n % 40 == 0) trend = $urandom_range(0, 800) - 400;
                pick = $urandom_range(0, 99);
                if (pick < 3) stamp = $urandom;
                else if (pick < 6) stamp = stamp;
                else stamp = stamp + 32'($urandom_range(1, step * 3));
                level = level + trend + $urandom_range(0, 40) - 20;
                if (level > 32767) level = 32767;
                if (level < -32768) level = -32768;
                sv = ($urandom_range(0, 99) < 10) ? $urandom_range(0, 65535) - 32768 : level;
                send_sample(16'(sv), stamp, 1'b0, blank);
            end
        end
        i_valid <= 1'b0;

        while (pending_rates.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Covered %0d samples over 8 register settings; %0d results checked.",
                 beats_in, beats_out);
        $display("Results with the limit exceeded: %0d, with the lock held: %0d.",
                 overs_out, locks_out);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ windowed_slope_runaway_monitor_core.f @@
+incdir+src
src/wsrm_pkg.sv
src/windowed_slope_runaway_monitor_core.sv
tb/testbench.sv
